@@ src/lce_pkg.sv @@
// shared types and constants of the lru cache with expiry
package lce_pkg;

  localparam int ENTRIES_DEF   = 16;
  localparam int DATA_BITS_DEF = 32;

  localparam int KEY_W      = 64;
  localparam int TIME_W     = 32;
  localparam int TTL_W      = 31;
  localparam int CAP_W      = 5;
  localparam int CNT_W      = 32;
  localparam int OCC_W      = 5;
  localparam int DOUT_W     = 32;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_TTL      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SEL,
    ST_UPD
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PROMOTE,
    OP_INSERT,
    OP_CLEAR
  } cell_op_t;

  typedef struct packed {
    logic     capture;
    cell_op_t op;
    logic     evict;
    logic     upd_data;
  } cell_ctl_t;

endpackage

@@ src/lce_cell.sv @@
// one cache slot: key compare, recency rank and free-slot priority link
module lce_cell
  import lce_pkg::*;
#(
  parameter int RW        = 4,
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_ctl_t            ctl,
  input  logic [RW-1:0]        lru_rank,
  input  logic [RW-1:0]        prom_rank,
  input  logic [KEY_W-1:0]     key,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [TIME_W-1:0]    now,
  input  logic                 free_in,
  output logic                 free_out,
  output logic                 match_o,
  output logic [DATA_BITS-1:0] match_data,
  output logic [TIME_W-1:0]    match_stamp,
  output logic [RW-1:0]        match_rank
);

  logic                 valid_r, valid_nxt;
  logic [RW-1:0]        rank_r, rank_nxt;
  logic [KEY_W-1:0]     key_r;
  logic [DATA_BITS-1:0] data_r;
  logic [TIME_W-1:0]    stamp_r;
  logic                 match_r, lru_r, free_r;
  logic                 free_pick, target, wr_entry, wr_payload;

  // a lower slot that is empty claims the free grant first
  assign free_out  = free_in | ~valid_r;
  assign free_pick = ~valid_r & ~free_in;

  assign target     = ctl.evict ? lru_r : free_r;
  assign wr_entry   = (ctl.op == OP_INSERT) && target;
  assign wr_payload = wr_entry || ((ctl.op == OP_PROMOTE) && match_r && ctl.upd_data);

  assign match_o     = match_r;
  assign match_data  = match_r ? data_r : '0;
  assign match_stamp = match_r ? stamp_r : '0;
  assign match_rank  = match_r ? rank_r : '0;

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    case (ctl.op)
      OP_PROMOTE: begin
        if (match_r) begin
          rank_nxt = '0;
        end else if (valid_r && (rank_r < prom_rank)) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      OP_INSERT: begin
        if (target) begin
          valid_nxt = 1'b1;
          rank_nxt  = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      OP_CLEAR: begin
        valid_nxt = 1'b0;
        rank_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
      match_r <= 1'b0;
      lru_r   <= 1'b0;
      free_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      if (ctl.capture) begin
        match_r <= valid_r && (key_r == key);
        lru_r   <= valid_r && (rank_r == lru_rank);
        free_r  <= free_pick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_entry) begin
      key_r <= key;
    end
    if (wr_payload) begin
      data_r  <= wdata;
      stamp_r <= now;
    end
  end

endmodule

@@ src/lru_cache_with_expiry.sv @@
// top level: command sequencer, cell chain, gather of the hit slot, counters
//
// Fully associative cache of 64-bit keys with lru replacement and an optional
// time-to-live. An item is taken when start is high and busy is low; it then
// runs through three steps (all cells compare the key and mark the least
// recent and the first free slot, the hit slot's data, stamp and rank are
// gathered, the update is broadcast back to the cells) and its result is on
// the out_ ports for one cycle after that, marked by out_valid, with no stall
// possible on the receiving side. Busy stays high meanwhile, so a new item is
// not taken before the last one has been through this three-step cell
// sequence. Valid bits and ranks clear at reset, so there is no clearing pass.
// Configuration writes are taken at any time with cfg_ready always high and
// must only be issued while busy is low and no result is pending.
module lru_cache_with_expiry
  import lce_pkg::*;
#(
  parameter int ENTRIES   = ENTRIES_DEF,
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_mode,
  input  logic [KEY_W-1:0]      in_key_value,
  input  logic [DOUT_W-1:0]     in_result_data,
  input  logic [TIME_W-1:0]     in_now_ms,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic [DOUT_W-1:0]     out_data_out,
  output logic [CNT_W-1:0]      out_hit_total,
  output logic [CNT_W-1:0]      out_miss_total,
  output logic [OCC_W-1:0]      out_occupancy,
  output logic                  out_evicted,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RW   = $clog2(ENTRIES);
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CAPX = (CW > CAP_W) ? CW : CAP_W;

  state_t state_r, state_nxt;

  logic [TTL_W-1:0] ttl_r;
  logic [CAP_W-1:0] cap_r;

  logic [1:0]           cmd_mode_r;
  logic [KEY_W-1:0]     cmd_key_r;
  logic [DATA_BITS-1:0] cmd_data_r;
  logic [TIME_W-1:0]    cmd_now_r;

  logic [CW-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0] hits_r, hits_nxt, miss_r, miss_nxt;

  logic                 sel_any_r;
  logic [DATA_BITS-1:0] sel_data_r;
  logic [TIME_W-1:0]    sel_stamp_r;
  logic [RW-1:0]        sel_rank_r;

  logic                 red_any;
  logic [DATA_BITS-1:0] red_data;
  logic [TIME_W-1:0]    red_stamp;
  logic [RW-1:0]        red_rank;

  logic capture, sel_en, upd_en;

  cell_op_t op_dec;
  logic     evict_dec, upd_data_dec, hit_dec;
  logic     stale;
  logic [TIME_W-1:0] age;
  logic [CAPX-1:0]   cap_x, cap_eff, count_x;

  cell_ctl_t     ctl;
  logic [RW-1:0] lru_rank;

  logic                 free_chain [ENTRIES+1];
  logic [ENTRIES-1:0]   m_hit;
  logic [DATA_BITS-1:0] m_data     [ENTRIES];
  logic [TIME_W-1:0]    m_stamp    [ENTRIES];
  logic [RW-1:0]        m_rank     [ENTRIES];

  logic                 out_valid_r, out_hit_r, out_evicted_r;
  logic [DOUT_W-1:0]    out_data_r;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= '0;
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TTL:      ttl_r <= cfg_data;
        REG_CAPACITY: cap_r <= cfg_data[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_MATCH;
      ST_MATCH: state_nxt = ST_SEL;
      ST_SEL:   state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b1;
    capture = 1'b0;
    sel_en  = 1'b0;
    upd_en  = 1'b0;
    unique case (state_r)
      ST_IDLE:  busy = 1'b0;
      ST_MATCH: capture = 1'b1;
      ST_SEL:   sel_en = 1'b1;
      ST_UPD:   upd_en = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_mode_r <= in_mode;
      cmd_key_r  <= in_key_value;
      cmd_data_r <= DATA_BITS'(in_result_data);
      cmd_now_r  <= in_now_ms;
    end
  end

  // cell chain
  assign lru_rank      = RW'(count_r - CW'(1));
  assign free_chain[0] = 1'b0;

  assign ctl.capture  = capture;
  assign ctl.op       = upd_en ? op_dec : OP_NONE;
  assign ctl.evict    = evict_dec;
  assign ctl.upd_data = upd_data_dec;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lce_cell #(
      .RW        (RW),
      .DATA_BITS (DATA_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .lru_rank    (lru_rank),
      .prom_rank   (sel_rank_r),
      .key         (cmd_key_r),
      .wdata       (cmd_data_r),
      .now         (cmd_now_r),
      .free_in     (free_chain[g]),
      .free_out    (free_chain[g+1]),
      .match_o     (m_hit[g]),
      .match_data  (m_data[g]),
      .match_stamp (m_stamp[g]),
      .match_rank  (m_rank[g])
    );
  end

  // at most one slot matches, so the gated slot outputs are simply or-ed
  always_comb begin
    red_any   = 1'b0;
    red_data  = '0;
    red_stamp = '0;
    red_rank  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      red_any   = red_any | m_hit[i];
      red_data  = red_data | m_data[i];
      red_stamp = red_stamp | m_stamp[i];
      red_rank  = red_rank | m_rank[i];
    end
  end

  always_ff @(posedge clk) begin
    if (sel_en) begin
      sel_any_r   <= red_any;
      sel_data_r  <= red_data;
      sel_stamp_r <= red_stamp;
      sel_rank_r  <= red_rank;
    end
  end

  // decision
  assign age     = cmd_now_r - sel_stamp_r;
  assign stale   = (ttl_r != '0) && (age > {1'b0, ttl_r});
  assign cap_x   = CAPX'(cap_r);
  assign count_x = CAPX'(count_r);

  always_comb begin
    if (cap_x == '0) begin
      cap_eff = CAPX'(1);
    end else if (cap_x > CAPX'(ENTRIES)) begin
      cap_eff = CAPX'(ENTRIES);
    end else begin
      cap_eff = cap_x;
    end
  end

  always_comb begin
    op_dec       = OP_NONE;
    evict_dec    = 1'b0;
    upd_data_dec = 1'b0;
    hit_dec      = 1'b0;
    count_nxt    = count_r;
    hits_nxt     = hits_r;
    miss_nxt     = miss_r;
    unique case (cmd_mode_r)
      MODE_LOOKUP: begin
        if (sel_any_r && !stale) begin
          op_dec   = OP_PROMOTE;
          hit_dec  = 1'b1;
          hits_nxt = (hits_r == CNT_MAX) ? hits_r : hits_r + 1'b1;
        end else begin
          miss_nxt = (miss_r == CNT_MAX) ? miss_r : miss_r + 1'b1;
        end
      end
      MODE_INSERT: begin
        if (sel_any_r) begin
          op_dec       = OP_PROMOTE;
          upd_data_dec = 1'b1;
        end else begin
          op_dec    = OP_INSERT;
          evict_dec = (count_x >= cap_eff);
          // an eviction frees one slot and refills it, occupancy unchanged
          if (!evict_dec) begin
            count_nxt = count_r + 1'b1;
          end
        end
      end
      MODE_CLEAR: begin
        op_dec    = OP_CLEAR;
        count_nxt = '0;
        hits_nxt  = '0;
        miss_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      hits_r      <= '0;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= upd_en;
      if (upd_en) begin
        count_r <= count_nxt;
        hits_r  <= hits_nxt;
        miss_r  <= miss_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      out_hit_r     <= hit_dec;
      out_evicted_r <= evict_dec && (op_dec == OP_INSERT);
      out_data_r    <= hit_dec ? DOUT_W'(sel_data_r) : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_data_out   = out_data_r;
  assign out_hit_total  = hits_r;
  assign out_miss_total = miss_r;
  assign out_occupancy  = OCC_W'(count_r);
  assign out_evicted    = out_evicted_r;

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_upd_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |=> out_valid && !busy)
    else $error("update cycle not followed by a result");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("occupancy above entry count");

  a_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted))
    else $error("hit and eviction in the same result");

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEL |-> $onehot0(m_hit))
    else $error("key present in more than one slot");

endmodule
